### rtl/hmac_pkg.sv
// ---------------------------------------------------------------------------
// hmac_pkg
// Shared types, codes, constants and SHA-256 functions for the HMAC engine.
// ---------------------------------------------------------------------------
package hmac_pkg;

    // Request codes on the input channel
    localparam logic [1:0] MODE_KEY_BYTE = 2'd0;
    localparam logic [1:0] MODE_MSG_BYTE = 2'd1;
    localparam logic [1:0] MODE_KEY_END  = 2'd2;
    localparam logic [1:0] MODE_MSG_END  = 2'd3;

    localparam logic [7:0] PAD_NONE  = 8'h00;
    localparam logic [7:0] PAD_INNER = 8'h36;
    localparam logic [7:0] PAD_OUTER = 8'h5C;
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [31:0] OUTER_LEN_BITS = 32'd768;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // Block window operations
    typedef enum logic [2:0] {
        WIN_NONE,
        WIN_KEY_PAD,
        WIN_PAD,
        WIN_LEN,
        WIN_ZERO_LEN,
        WIN_OUTER,
        WIN_MSG_BYTE
    } t_win_op;

    // Key store operations
    typedef enum logic [1:0] {
        KEY_NONE,
        KEY_CLEAR,
        KEY_WRITE,
        KEY_FROM_CHAIN
    } t_key_op;

    typedef struct packed {
        t_win_op    win_op;
        t_key_op    key_op;
        logic       src_msg;
        logic [7:0] pad;
        logic [7:0] data_byte;
        logic       chain_iv;
        logic       start;
        logic       inner_save;
        logic       msg_clear;
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic        busy;
        logic        key_blk;
        logic        key_is64;
        logic        key_gt64;
        logic        key_n0;
        logic        key_ge56;
        logic        msg_last;
        logic        msg_ge56;
        logic [31:0] digest_word;
    } t_stat;

    function automatic logic [31:0] sha_iv(input logic [2:0] i);
        logic [31:0] v;
        begin
            case (i)
                3'd0:    v = 32'h6a09e667;
                3'd1:    v = 32'hbb67ae85;
                3'd2:    v = 32'h3c6ef372;
                3'd3:    v = 32'ha54ff53a;
                3'd4:    v = 32'h510e527f;
                3'd5:    v = 32'h9b05688c;
                3'd6:    v = 32'h1f83d9ab;
                default: v = 32'h5be0cd19;
            endcase
            return v;
        end
    endfunction

    function automatic logic [31:0] sha_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

endpackage

### rtl/hmac_dp.sv
// ---------------------------------------------------------------------------
// hmac_dp
// Datapath: key store, byte counters, block window with rolling message
// schedule, chain value and one SHA-256 round per cycle.
// ---------------------------------------------------------------------------
module hmac_dp import hmac_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    output t_stat o_stat
);

    // Key store as 16 big-endian words
    logic [31:0] r_key [16];
    logic [31:0] n_key [16];
    logic [63:0] r_kcnt, n_kcnt;
    logic [63:0] r_mcnt, n_mcnt;
    logic [31:0] r_chain [8];
    logic [31:0] n_chain [8];
    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [31:0] r_inner [8];
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_fin;

    logic [7:0]  wb [64];
    logic [5:0]  pad_n;
    logic [63:0] msg_len;
    logic [63:0] len_bits;
    logic [31:0] t1, t2, w_new;
    logic        rounding;

    assign rounding = r_busy && !r_fin;

    // View the window as bytes, big-endian inside each word
    always_comb begin
        for (int i = 0; i < 64; i++) begin
            wb[i] = r_w[i / 4][(8 * (3 - (i % 4))) +: 8];
        end
    end

    assign pad_n    = i_cmd.src_msg ? r_mcnt[5:0] : r_kcnt[5:0];
    assign msg_len  = r_mcnt + 64'd64;
    assign len_bits = i_cmd.src_msg ? {msg_len[60:0], 3'b000} : {r_kcnt[60:0], 3'b000};

    // One compression round and the next schedule word
    always_comb begin
        t1 = r_v[7] + (rotr(r_v[4], 5'd6) ^ rotr(r_v[4], 5'd11) ^ rotr(r_v[4], 5'd25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + sha_k(r_rnd) + r_w[0];
        t2 = (rotr(r_v[0], 5'd2) ^ rotr(r_v[0], 5'd13) ^ rotr(r_v[0], 5'd22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_new = (rotr(r_w[14], 5'd17) ^ rotr(r_w[14], 5'd19) ^ (r_w[14] >> 10))
              + r_w[9]
              + (rotr(r_w[1], 5'd7) ^ rotr(r_w[1], 5'd18) ^ (r_w[1] >> 3))
              + r_w[0];
    end

    // Next window
    always_comb begin
        logic [7:0] b;
        b = 8'h00;
        for (int i = 0; i < 16; i++) n_w[i] = r_w[i];
        if (rounding) begin
            for (int i = 0; i < 15; i++) n_w[i] = r_w[i + 1];
            n_w[15] = w_new;
        end else begin
            case (i_cmd.win_op)
                WIN_KEY_PAD: begin
                    for (int i = 0; i < 16; i++) n_w[i] = r_key[i] ^ {4{i_cmd.pad}};
                end
                WIN_PAD: begin
                    for (int i = 0; i < 64; i++) begin
                        if (i < pad_n) begin
                            b = i_cmd.src_msg ? wb[i] : r_key[i / 4][(8 * (3 - (i % 4))) +: 8];
                        end else if (i == pad_n) begin
                            b = PAD_MARK;
                        end else begin
                            b = 8'h00;
                        end
                        n_w[i / 4][(8 * (3 - (i % 4))) +: 8] = b;
                    end
                end
                WIN_LEN: begin
                    n_w[14] = len_bits[63:32];
                    n_w[15] = len_bits[31:0];
                end
                WIN_ZERO_LEN: begin
                    for (int i = 0; i < 14; i++) n_w[i] = '0;
                    n_w[14] = len_bits[63:32];
                    n_w[15] = len_bits[31:0];
                end
                WIN_OUTER: begin
                    for (int i = 0; i < 8; i++) n_w[i] = r_inner[i];
                    for (int i = 8; i < 16; i++) n_w[i] = '0;
                    n_w[8]  = {PAD_MARK, 24'h000000};
                    n_w[15] = OUTER_LEN_BITS;
                end
                WIN_MSG_BYTE: begin
                    n_w[r_mcnt[5:2]][(8 * (3 - r_mcnt[1:0])) +: 8] = i_cmd.data_byte;
                end
                default: ;
            endcase
        end
    end

    // Next key store and counters
    always_comb begin
        for (int i = 0; i < 16; i++) n_key[i] = r_key[i];
        n_kcnt = r_kcnt;
        n_mcnt = r_mcnt;
        case (i_cmd.key_op)
            KEY_CLEAR: begin
                for (int i = 0; i < 16; i++) n_key[i] = '0;
                n_kcnt = '0;
            end
            KEY_WRITE: begin
                n_key[r_kcnt[5:2]][(8 * (3 - r_kcnt[1:0])) +: 8] = i_cmd.data_byte;
                n_kcnt = r_kcnt + 64'd1;
            end
            KEY_FROM_CHAIN: begin
                for (int i = 0; i < 8; i++) n_key[i] = r_chain[i];
                for (int i = 8; i < 16; i++) n_key[i] = '0;
            end
            default: ;
        endcase
        if (i_cmd.win_op == WIN_MSG_BYTE) n_mcnt = r_mcnt + 64'd1;
        if (i_cmd.msg_clear) n_mcnt = '0;
    end

    // Next chain and working variables
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n_chain[i] = r_chain[i];
            n_v[i]     = r_v[i];
        end
        if (r_fin) begin
            for (int i = 0; i < 8; i++) n_chain[i] = r_chain[i] + r_v[i];
        end else if (rounding) begin
            for (int i = 1; i < 8; i++) n_v[i] = r_v[i - 1];
            n_v[4] = r_v[3] + t1;
            n_v[0] = t1 + t2;
        end else begin
            if (i_cmd.chain_iv) begin
                for (int i = 0; i < 8; i++) n_chain[i] = sha_iv(3'(i));
            end
            if (i_cmd.start) begin
                for (int i = 0; i < 8; i++) n_v[i] = i_cmd.chain_iv ? sha_iv(3'(i)) : r_chain[i];
            end
        end
    end

    // Hold payload state
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) r_w[i] <= n_w[i];
        for (int i = 0; i < 8; i++) r_v[i] <= n_v[i];
        if (i_cmd.inner_save && !r_busy) begin
            for (int i = 0; i < 8; i++) r_inner[i] <= r_chain[i];
        end
    end

    // Hold control state, key and chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_key[i] <= '0;
            for (int i = 0; i < 8; i++) r_chain[i] <= sha_iv(3'(i));
            r_kcnt <= '0;
            r_mcnt <= '0;
            r_rnd  <= '0;
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            for (int i = 0; i < 16; i++) r_key[i] <= n_key[i];
            for (int i = 0; i < 8; i++) r_chain[i] <= n_chain[i];
            r_kcnt <= n_kcnt;
            r_mcnt <= n_mcnt;
            if (r_fin) begin
                r_fin  <= 1'b0;
                r_busy <= 1'b0;
            end else if (rounding) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) r_fin <= 1'b1;
            end else if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end
        end
    end

    // Report status
    always_comb begin
        o_stat.busy        = r_busy;
        o_stat.key_blk     = (|r_kcnt[63:6]) && (r_kcnt[5:0] == 6'd0);
        o_stat.key_is64    = (r_kcnt == 64'd64);
        o_stat.key_gt64    = (|r_kcnt[63:7]) || (r_kcnt[6] && (|r_kcnt[5:0]));
        o_stat.key_n0      = (r_kcnt[5:0] == 6'd0);
        o_stat.key_ge56    = (r_kcnt[5:3] == 3'd7);
        o_stat.msg_last    = (r_mcnt[5:0] == 6'd63);
        o_stat.msg_ge56    = (r_mcnt[5:3] == 3'd7);
        o_stat.digest_word = r_chain[i_cmd.out_idx];
    end

endmodule

### rtl/hmac_ctrl.sv
// ---------------------------------------------------------------------------
// hmac_ctrl
// Controller: decodes requests, sequences key hashing, padding and the
// inner/outer passes, and hands out the eight digest words.
// ---------------------------------------------------------------------------
module hmac_ctrl import hmac_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_in   i_in,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_out  o_out,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_WAIT, S_KPUSH, S_KEY_WR, S_MSG,
        S_KC0, S_KC1, S_KC_LEN, S_KC_SET,
        S_INNER, S_MC1, S_MC_LEN, S_MC_OUT1, S_MC_OUT2, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_KEY, PH_READY, PH_MSG
    } t_phase;

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    t_phase     r_phase, n_phase;
    logic [7:0] r_byte;
    logic [2:0] r_idx, n_idx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out.digest_word = i_stat.digest_word;
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == 3'd7);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_phase = r_phase;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.win_op    = WIN_NONE;
        o_cmd.key_op    = KEY_NONE;
        o_cmd.data_byte = r_byte;
        o_cmd.out_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in.mode)
                        MODE_KEY_BYTE: if (r_phase != PH_MSG) n_state = S_KPUSH;
                        MODE_MSG_BYTE: if (r_phase != PH_KEY) n_state = S_MSG;
                        MODE_KEY_END:  if (r_phase == PH_KEY) n_state = S_KC0;
                        default:       if (r_phase != PH_KEY) n_state = S_MC1;
                    endcase
                    // A key byte after a finished key opens a new key
                    if (i_in.mode == MODE_KEY_BYTE && r_phase == PH_READY) begin
                        o_cmd.key_op = KEY_CLEAR;
                        n_phase = PH_KEY;
                    end
                end
            end
            S_WAIT: begin
                if (!i_stat.busy) n_state = r_ret;
            end
            S_KPUSH: begin
                // Hash a full 64-byte key block before storing the next byte
                if (i_stat.key_blk) begin
                    o_cmd.chain_iv = i_stat.key_is64;
                    o_cmd.win_op   = WIN_KEY_PAD;
                    o_cmd.pad      = PAD_NONE;
                    o_cmd.start    = 1'b1;
                    n_ret   = S_KEY_WR;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_KEY_WR;
                end
            end
            S_KEY_WR: begin
                o_cmd.key_op = KEY_WRITE;
                n_state = S_IDLE;
            end
            S_MSG: begin
                o_cmd.win_op = WIN_MSG_BYTE;
                n_phase = PH_MSG;
                if (i_stat.msg_last) begin
                    o_cmd.start = 1'b1;
                    n_ret   = S_IDLE;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_KC0: begin
                if (!i_stat.key_gt64) begin
                    n_state = S_INNER;
                end else if (i_stat.key_n0) begin
                    o_cmd.win_op = WIN_KEY_PAD;
                    o_cmd.pad    = PAD_NONE;
                    o_cmd.start  = 1'b1;
                    n_ret   = S_KC1;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_KC1;
                end
            end
            S_KC1: begin
                o_cmd.win_op = WIN_PAD;
                if (i_stat.key_ge56) begin
                    o_cmd.start = 1'b1;
                    n_ret   = S_KC_LEN;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_KC_LEN;
                end
            end
            S_KC_LEN: begin
                o_cmd.win_op = i_stat.key_ge56 ? WIN_ZERO_LEN : WIN_LEN;
                o_cmd.start  = 1'b1;
                n_ret   = S_KC_SET;
                n_state = S_WAIT;
            end
            S_KC_SET: begin
                o_cmd.key_op = KEY_FROM_CHAIN;
                n_state = S_INNER;
            end
            S_INNER: begin
                o_cmd.chain_iv  = 1'b1;
                o_cmd.win_op    = WIN_KEY_PAD;
                o_cmd.pad       = PAD_INNER;
                o_cmd.start     = 1'b1;
                o_cmd.msg_clear = 1'b1;
                n_phase = PH_READY;
                n_ret   = S_IDLE;
                n_state = S_WAIT;
            end
            S_MC1: begin
                o_cmd.src_msg = 1'b1;
                o_cmd.win_op  = WIN_PAD;
                if (i_stat.msg_ge56) begin
                    o_cmd.start = 1'b1;
                    n_ret   = S_MC_LEN;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_MC_LEN;
                end
            end
            S_MC_LEN: begin
                o_cmd.src_msg = 1'b1;
                o_cmd.win_op  = i_stat.msg_ge56 ? WIN_ZERO_LEN : WIN_LEN;
                o_cmd.start   = 1'b1;
                n_ret   = S_MC_OUT1;
                n_state = S_WAIT;
            end
            S_MC_OUT1: begin
                o_cmd.inner_save = 1'b1;
                o_cmd.chain_iv   = 1'b1;
                o_cmd.win_op     = WIN_KEY_PAD;
                o_cmd.pad        = PAD_OUTER;
                o_cmd.start      = 1'b1;
                n_ret   = S_MC_OUT2;
                n_state = S_WAIT;
            end
            S_MC_OUT2: begin
                o_cmd.win_op = WIN_OUTER;
                o_cmd.start  = 1'b1;
                n_ret   = S_OUT;
                n_state = S_WAIT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) n_state = S_INNER;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, phase and the latched request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_phase <= PH_KEY;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_in.data_byte;
        end
    end

endmodule

### rtl/hmac_sha256_engine_core.sv
// ---------------------------------------------------------------------------
// hmac_sha256_engine_core
// HMAC-SHA256 over byte streams: key entry, inner pass, outer pass and a
// digest of eight big-endian words.
// ---------------------------------------------------------------------------
//  channel | handshake                 | payload
//  input   | i_in_valid / o_in_ready   | i_in  (mode, data_byte)
//  output  | o_out_valid / i_out_ready | o_out (digest_word, word_index, last_word)
//
//  A message byte that fills a block, or a key byte that follows a full key block,
//  adds a compression: 64 rounds of the single round unit plus the chain add.
//  End of key takes up to 3 compressions, end of message 3 or 4 compressions plus
//  the 8 word transfers and the next inner pad pass.
//  Reset is synchronous; one request is in flight at a time and a stalled
//  output holds the block until all eight words are taken.
// ---------------------------------------------------------------------------
module hmac_sha256_engine_core import hmac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_cmd  cmd;
    t_stat stat;

    hmac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    hmac_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

### rtl/hmac_chk.sv
// ---------------------------------------------------------------------------
// hmac_chk
// Port-level checks for the HMAC engine, bound to the top level.
// ---------------------------------------------------------------------------
module hmac_chk import hmac_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // Drop input ready while results wait
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready during result delivery");

    // Advance word index after each taken word
    a_word_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last_word |=>
            o_out_valid && (o_out.word_index == $past(o_out.word_index) + 3'd1))
        else $error("digest word sequence broken");

    // Flag the last word exactly at index seven
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last_word == (o_out.word_index == 3'd7)))
        else $error("last_word mismatch");

    // Close the burst after the last word
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.last_word |=> !o_out_valid)
        else $error("result after last word");

endmodule

bind hmac_sha256_engine_core hmac_chk u_hmac_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
